>>> design/rotary_encoder_event_queue_core_defines.svh
// Assertion macros for the rotary encoder event queue core.
`ifndef ROTARY_ENCODER_EVENT_QUEUE_CORE_DEFINES_SVH
`define ROTARY_ENCODER_EVENT_QUEUE_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define REEQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define REEQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/reeq_pkg.sv
// Shared types, codes and defaults for the rotary encoder event queue.
package reeq_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 16;
   localparam int TICK_W = 8;

   localparam logic [TICK_W-1:0] QUAD_DEBOUNCE_RESET   = 8'd5;
   localparam logic [TICK_W-1:0] BUTTON_DEBOUNCE_RESET = 8'd100;

   // request kind carried in tuser
   localparam logic FUNC_TICK = 1'b0;
   localparam logic FUNC_POP  = 1'b1;

   // configuration register indexes
   localparam logic CSR_QUAD_DEBOUNCE   = 1'b0;
   localparam logic CSR_BUTTON_DEBOUNCE = 1'b1;

   typedef logic [1:0] event_code_type;

   localparam event_code_type EV_NONE  = 2'd0;
   localparam event_code_type EV_CCW   = 2'd1;
   localparam event_code_type EV_CW    = 2'd2;
   localparam event_code_type EV_PRESS = 2'd3;

   // events raised by one tick, in push order ccw/cw first, press last
   typedef struct packed {
      logic ccw;
      logic cw;
      logic press;
   } event_req_type;

endpackage

>>> design/reeq_debounce.sv
// Edge detection and debounce counters for encoder lines A, B and the button.
module reeq_debounce (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              tick_en,
   input  logic                              line_a,
   input  logic                              line_b,
   input  logic                              button_level,
   input  logic [reeq_pkg::TICK_W-1:0]       quad_ticks,
   input  logic [reeq_pkg::TICK_W-1:0]       button_ticks,
   output reeq_pkg::event_req_type           events
);

   logic                        last_a_ff, last_b_ff, last_btn_ff;
   logic [reeq_pkg::TICK_W-1:0] elapsed_a_ff, elapsed_b_ff, elapsed_btn_ff;
   logic [reeq_pkg::TICK_W-1:0] elapsed_a_in, elapsed_b_in, elapsed_btn_in;
   logic                        edge_a, edge_b, fall_btn;

   function automatic logic [reeq_pkg::TICK_W-1:0] sat_inc(
      input logic [reeq_pkg::TICK_W-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   always_comb begin
      edge_a   = line_a != last_a_ff;
      edge_b   = line_b != last_b_ff;
      fall_btn = last_btn_ff && !button_level;

      // counters are compared as stored, before the restart
      events.ccw   = edge_a && (elapsed_a_ff > quad_ticks) && (line_a != line_b);
      events.cw    = edge_b && (elapsed_b_ff > quad_ticks) && (line_b != line_a);
      events.press = fall_btn && (elapsed_btn_ff > button_ticks);

      elapsed_a_in   = edge_a   ? '0 : sat_inc(elapsed_a_ff);
      elapsed_b_in   = edge_b   ? '0 : sat_inc(elapsed_b_ff);
      elapsed_btn_in = fall_btn ? '0 : sat_inc(elapsed_btn_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_a_ff      <= 1'b1;
         last_b_ff      <= 1'b1;
         last_btn_ff    <= 1'b1;
         elapsed_a_ff   <= '0;
         elapsed_b_ff   <= '0;
         elapsed_btn_ff <= '0;
      end else if (tick_en) begin
         last_a_ff      <= line_a;
         last_b_ff      <= line_b;
         last_btn_ff    <= button_level;
         elapsed_a_ff   <= elapsed_a_in;
         elapsed_b_ff   <= elapsed_b_in;
         elapsed_btn_ff <= elapsed_btn_in;
      end
   end

endmodule

>>> design/reeq_fifo.sv
// Event FIFO built from three interleaved lanes so one tick can push three events.
module reeq_fifo #(
   parameter int  QUEUE_DEPTH = reeq_pkg::QUEUE_DEPTH_DEFAULT,
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          push_en,
   input  logic                          pop_en,
   input  reeq_pkg::event_req_type       events,
   output logic [CNT_W-1:0]              count,
   output logic                          dropped,
   output reeq_pkg::event_code_type      event_code
);

   localparam int LANES     = 3;
   localparam int ROWS_RAW  = (QUEUE_DEPTH + LANES - 1) / LANES;
   localparam int BANK_ROWS = (ROWS_RAW < 2) ? 2 : ROWS_RAW;
   localparam int ROW_W     = $clog2(BANK_ROWS);

   logic [CNT_W-1:0]         count_ff, count_in;
   logic [ROW_W-1:0]         wr_row_ff, wr_row_in, rd_row_ff, rd_row_in;
   logic [1:0]               wr_lane_ff, wr_lane_in, rd_lane_ff, rd_lane_in;
   logic                     hit_ff;
   logic [1:0]               sel_lane_ff;
   reeq_pkg::event_code_type rd_code_ff [LANES];

   reeq_pkg::event_code_type ev_list [LANES];
   logic [1:0]               n_req, n_wr, wr_cnt;
   logic [CNT_W-1:0]         free_slots;
   logic                     too_many, pop_hit;
   logic [2:0]               wr_sum;

   logic [LANES-1:0]         bank_we;
   logic [ROW_W-1:0]         bank_row  [LANES];
   reeq_pkg::event_code_type bank_code [LANES];

   function automatic logic [ROW_W-1:0] row_inc(input logic [ROW_W-1:0] r);
      return (r == ROW_W'(BANK_ROWS - 1)) ? '0 : r + 1'b1;
   endfunction

   // position of lane g within a push group that starts at lane l
   function automatic logic [1:0] lane_dist(input logic [1:0] g, input logic [1:0] l);
      return (g >= l) ? g - l : g + 2'(LANES) - l;
   endfunction

   always_comb begin
      n_req = {1'b0, events.ccw} + {1'b0, events.cw} + {1'b0, events.press};

      // compacted push list in A, B, button order
      ev_list[0] = events.ccw ? reeq_pkg::EV_CCW
                 : (events.cw ? reeq_pkg::EV_CW : reeq_pkg::EV_PRESS);
      ev_list[1] = (events.ccw && events.cw) ? reeq_pkg::EV_CW : reeq_pkg::EV_PRESS;
      ev_list[2] = reeq_pkg::EV_PRESS;

      free_slots = CNT_W'(QUEUE_DEPTH) - count_ff;
      too_many   = CNT_W'(n_req) > free_slots;
      n_wr       = too_many ? free_slots[1:0] : n_req;
      dropped    = push_en && too_many;
      wr_cnt     = push_en ? n_wr : 2'd0;
      pop_hit    = pop_en && (count_ff != '0);

      count_in = count_ff + CNT_W'(wr_cnt) - CNT_W'(pop_hit);

      wr_sum = {1'b0, wr_lane_ff} + {1'b0, wr_cnt};
      if (wr_sum >= 3'(LANES)) begin
         wr_lane_in = 2'(wr_sum - 3'(LANES));
         wr_row_in  = row_inc(wr_row_ff);
      end else begin
         wr_lane_in = wr_sum[1:0];
         wr_row_in  = wr_row_ff;
      end

      rd_lane_in = rd_lane_ff;
      rd_row_in  = rd_row_ff;
      if (pop_hit) begin
         if (rd_lane_ff == 2'(LANES - 1)) begin
            rd_lane_in = '0;
            rd_row_in  = row_inc(rd_row_ff);
         end else begin
            rd_lane_in = rd_lane_ff + 1'b1;
         end
      end

      for (int g = 0; g < LANES; g++) begin
         bank_we[g]   = push_en && (lane_dist(2'(g), wr_lane_ff) < n_wr);
         bank_row[g]  = (2'(g) < wr_lane_ff) ? row_inc(wr_row_ff) : wr_row_ff;
         bank_code[g] = ev_list[lane_dist(2'(g), wr_lane_ff)];
      end
   end

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      reeq_pkg::event_code_type lane_mem [BANK_ROWS];

      always_ff @(posedge clock) begin
         if (bank_we[g]) begin
            lane_mem[bank_row[g]] <= bank_code[g];
         end
         if (advance) begin
            rd_code_ff[g] <= lane_mem[rd_row_ff];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         wr_row_ff  <= '0;
         wr_lane_ff <= '0;
         rd_row_ff  <= '0;
         rd_lane_ff <= '0;
         hit_ff     <= 1'b0;
      end else if (advance) begin
         count_ff   <= count_in;
         wr_row_ff  <= wr_row_in;
         wr_lane_ff <= wr_lane_in;
         rd_row_ff  <= rd_row_in;
         rd_lane_ff <= rd_lane_in;
         hit_ff     <= pop_hit;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sel_lane_ff <= rd_lane_ff;
      end
   end

   assign count      = count_ff;
   assign event_code = hit_ff ? rd_code_ff[sel_lane_ff] : reeq_pkg::EV_NONE;

endmodule

>>> design/rotary_encoder_event_queue_core.sv
// Rotary encoder event queue: one item per cycle while the response side
// accepts, through an input register, then a result register. Each request
// transaction is either a tick carrying pin samples (tuser low) or a pop of
// the oldest queued event (tuser high), and each yields exactly one response
// transaction. Debounce counters and queue pointers update together; up to
// three events from one tick are written at once into three interleaved lanes
// of max(2, ceil(QUEUE_DEPTH/3)) rows; the queue needs no clearing pass after reset.
// The user writes debounce thresholds through the csr port only while idle (not enforced).
`include "rotary_encoder_event_queue_core_defines.svh"

module rotary_encoder_event_queue_core #(
   parameter int QUEUE_DEPTH = reeq_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // line_a, line_b, button_level, zero pad
   input  logic       req_tuser,   // func
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // event_code[1:0], pending[6:2], overflow[7]
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic [7:0] csr_wdata
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [reeq_pkg::TICK_W-1:0] quad_ticks_ff, button_ticks_ff;
   logic                        in_valid_ff, in_valid_in;
   logic                        in_func_ff, in_a_ff, in_b_ff, in_btn_ff;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        overflow_ff;

   logic                        adv, tick_en, pop_en;
   reeq_pkg::event_req_type     events;
   logic [CNT_W-1:0]            fifo_count;
   logic                        fifo_dropped;
   reeq_pkg::event_code_type    fifo_code;

   always_comb begin
      adv          = in_valid_ff && (!rsp_valid_ff || rsp_tready);
      req_tready   = !in_valid_ff || adv;
      tick_en      = adv && (in_func_ff == reeq_pkg::FUNC_TICK);
      pop_en       = adv && (in_func_ff == reeq_pkg::FUNC_POP);
      in_valid_in  = req_tready ? req_tvalid : in_valid_ff;
      rsp_valid_in = adv ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   reeq_debounce u_debounce (
      .clock        (clock),
      .reset        (reset),
      .tick_en      (tick_en),
      .line_a       (in_a_ff),
      .line_b       (in_b_ff),
      .button_level (in_btn_ff),
      .quad_ticks   (quad_ticks_ff),
      .button_ticks (button_ticks_ff),
      .events       (events)
   );

   reeq_fifo #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .advance    (adv),
      .push_en    (tick_en),
      .pop_en     (pop_en),
      .events     (events),
      .count      (fifo_count),
      .dropped    (fifo_dropped),
      .event_code (fifo_code)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         quad_ticks_ff   <= reeq_pkg::QUAD_DEBOUNCE_RESET;
         button_ticks_ff <= reeq_pkg::BUTTON_DEBOUNCE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               reeq_pkg::CSR_QUAD_DEBOUNCE:   quad_ticks_ff   <= csr_wdata;
               reeq_pkg::CSR_BUTTON_DEBOUNCE: button_ticks_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_func_ff <= req_tuser;
         in_a_ff    <= req_tdata[0];
         in_b_ff    <= req_tdata[1];
         in_btn_ff  <= req_tdata[2];
      end
      if (adv) begin
         overflow_ff <= fifo_dropped;
      end
   end

   // queue count only moves when a new result is loaded, so it tracks the
   // result on display
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {overflow_ff, 5'(fifo_count), fifo_code};

   `REEQ_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, fifo_count <= QUEUE_DEPTH, "queue count beyond depth")
   `REEQ_ASSERT_NEXT(a_drop_full, clock, reset, tick_en && fifo_dropped, fifo_count == QUEUE_DEPTH, "event dropped with room left")
   `REEQ_ASSERT_NEXT(a_pop_dec, clock, reset, pop_en && (fifo_count != '0), fifo_count == $past(fifo_count) - 1'b1, "pop did not remove one event")
   `REEQ_ASSERT_NOW(a_stall_chain, clock, reset, in_valid_ff && !req_tready, rsp_valid_ff && !rsp_tready, "input stalled without output backpressure")

endmodule

>>> bench/tb_rotary_encoder_event_queue_core.sv
// Testbench for the rotary encoder event queue core: stream stimulus, in-bench predictor, checks.
module tb_rotary_encoder_event_queue_core;

   localparam int FIFO_DEPTH  = reeq_pkg::QUEUE_DEPTH_DEFAULT;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_ITEMS = 207;

   typedef struct {
      logic func;
      logic a;
      logic b;
      logic btn;
   } encoder_req_type;

   typedef struct {
      reeq_pkg::event_code_type code;
      logic [4:0]               pending;
      logic                     overflow;
   } encoder_rsp_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'd0;   // line_a, line_b, button_level, zero pad
   logic       req_tuser = 1'b0;   // func
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;          // event_code[1:0], pending[6:2], overflow[7]
   logic       csr_we = 1'b0;
   logic       csr_index = 1'b0;
   logic [7:0] csr_wdata = 8'd0;

   rotary_encoder_event_queue_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic [7:0]               quad_thr = reeq_pkg::QUAD_DEBOUNCE_RESET;
   logic [7:0]               btn_thr  = reeq_pkg::BUTTON_DEBOUNCE_RESET;
   logic                     prev_a = 1'b1, prev_b = 1'b1, prev_btn = 1'b1;
   logic [7:0]               age_a = 8'd0, age_b = 8'd0, age_btn = 8'd0;
   reeq_pkg::event_code_type stored_events[$];
   encoder_rsp_type          expected_rsps[$];

   // stimulus state
   encoder_req_type stim_items[$];
   int              queued_items = 0;
   logic            gen_a = 1'b1, gen_b = 1'b1, gen_btn = 1'b1;
   int              pop_pct = 15;
   int              send_idle_pct = 0;
   int              recv_stall_pct = 0;

   int mismatches = 0;
   int cycle_count = 0;

   function automatic logic [7:0] age_step(input logic [7:0] v);
      return (v == 8'hFF) ? v : v + 8'd1;
   endfunction

   // returns 1 when the queue is full and the event is lost
   function automatic logic fifo_push(input reeq_pkg::event_code_type code);
      if (stored_events.size() >= FIFO_DEPTH) return 1'b1;
      stored_events.push_back(code);
      return 1'b0;
   endfunction

   task automatic predict_encoder(input logic func, input logic a, input logic b,
                                  input logic btn);
      encoder_rsp_type r;
      logic            hit_a, hit_b, hit_btn, dropped;
      r.code  = reeq_pkg::EV_NONE;
      hit_a   = 1'b0;
      hit_b   = 1'b0;
      hit_btn = 1'b0;
      dropped = 1'b0;
      if (func == reeq_pkg::FUNC_TICK) begin
         if (a != prev_a) begin
            hit_a = age_a > quad_thr;
            age_a = 8'd0;
         end else begin
            age_a = age_step(age_a);
         end
         if (b != prev_b) begin
            hit_b = age_b > quad_thr;
            age_b = 8'd0;
         end else begin
            age_b = age_step(age_b);
         end
         // only a falling button edge restarts its counter
         if (prev_btn && !btn) begin
            hit_btn = age_btn > btn_thr;
            age_btn = 8'd0;
         end else begin
            age_btn = age_step(age_btn);
         end
         prev_a   = a;
         prev_b   = b;
         prev_btn = btn;
         if (hit_a && a != b) dropped = fifo_push(reeq_pkg::EV_CCW) | dropped;
         if (hit_b && b != a) dropped = fifo_push(reeq_pkg::EV_CW) | dropped;
         if (hit_btn) dropped = fifo_push(reeq_pkg::EV_PRESS) | dropped;
      end else if (stored_events.size() > 0) begin
         r.code = stored_events.pop_front();
      end
      r.pending  = 5'(stored_events.size());
      r.overflow = dropped;
      expected_rsps.push_back(r);
   endtask

   // driver
   always @(posedge clock) begin
      encoder_req_type item;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) predict_encoder(req_tuser, req_tdata[0], req_tdata[1], req_tdata[2]);
         if (stim_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            item = stim_items.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {5'd0, item.btn, item.b, item.a};
            req_tuser  <= item.func;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      encoder_rsp_type want;
      encoder_rsp_type got;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         if (rsp_tvalid && rsp_tready) begin
            got.code     = rsp_tdata[1:0];
            got.pending  = rsp_tdata[6:2];
            got.overflow = rsp_tdata[7];
            if (expected_rsps.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected response transaction: tdata=%h", rsp_tdata);
            end else begin
               want = expected_rsps.pop_front();
               if (got.code !== want.code || got.pending !== want.pending ||
                   got.overflow !== want.overflow) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"mismatch: expected code=%0d pending=%0d overflow=%0d,",
                               " got code=%0d pending=%0d overflow=%0d"},
                              want.code, want.pending, want.overflow,
                              got.code, got.pending, got.overflow);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_rotary_encoder_event_queue_core: FAIL");
         $finish;
      end
   end

   task automatic add_item(input logic func, input logic a, input logic b, input logic btn);
      stim_items.push_back('{func, a, b, btn});
      queued_items++;
   endtask

   task automatic hold_levels(input int n);
      repeat (n) add_item(reeq_pkg::FUNC_TICK, gen_a, gen_b, gen_btn);
   endtask

   // hold lengths straddle thresholds up to 120 so edges land on both sides; larger get short holds
   function automatic int pick_hold(input int thr);
      if (thr > 120) return $urandom_range(0, 10);
      return $urandom_range(thr > 2 ? thr - 2 : 0, thr + 3);
   endfunction

   // one gray-code step; clockwise toggles B from an equal pair, A from an unequal one
   task automatic rotate_step(input logic cw);
      if (cw ^ (gen_a != gen_b)) gen_b = !gen_b;
      else gen_a = !gen_a;
      hold_levels(1);
      hold_levels(pick_hold(quad_thr));
   endtask

   task automatic press_button();
      int low_ticks;
      int rest;
      low_ticks = $urandom_range(0, 3);
      gen_btn = 1'b0;
      hold_levels(1 + low_ticks);
      gen_btn = 1'b1;
      rest = pick_hold(btn_thr) - low_ticks - 1;
      hold_levels(1 + (rest > 0 ? rest : 0));
   endtask

   task automatic random_segment(input int n);
      int start;
      int r;
      start = queued_items;
      while (queued_items - start < n) begin
         // move between filling and draining the queue now and then
         if ($urandom_range(99) < 3) begin
            case ($urandom_range(2))
               0: pop_pct = 4;
               1: pop_pct = 15;
               default: pop_pct = 45;
            endcase
         end
         r = $urandom_range(99);
         if (r < pop_pct) begin
            repeat ($urandom_range(1, 6))
               add_item(reeq_pkg::FUNC_POP, 1'($urandom_range(1)), 1'($urandom_range(1)),
                        1'($urandom_range(1)));
         end else if (r < pop_pct + 40) begin
            rotate_step(1'($urandom_range(1)));
         end else if (r < pop_pct + 52) begin
            press_button();
         end else begin
            repeat ($urandom_range(1, 3)) begin
               gen_a   = 1'($urandom_range(1));
               gen_b   = 1'($urandom_range(1));
               gen_btn = 1'($urandom_range(1));
               hold_levels(1);
            end
         end
      end
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (stim_items.size() != 0 || req_tvalid || expected_rsps.size() != 0);
   endtask

   task automatic set_threshold(input logic idx, input logic [7:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == reeq_pkg::CSR_QUAD_DEBOUNCE) quad_thr = val;
      else btn_thr = val;
   endtask

   task automatic run_phase(input int quad, input int btn, input int send_pct,
                            input int stall_pct);
      wait_idle();
      set_threshold(reeq_pkg::CSR_QUAD_DEBOUNCE, 8'(quad));
      set_threshold(reeq_pkg::CSR_BUTTON_DEBOUNCE, 8'(btn));
      @(negedge clock);
      send_idle_pct  = send_pct;
      recv_stall_pct = stall_pct;
      // long quiet stretch drives every counter into saturation
      if (quad == 255 && btn == 255) hold_levels(260);
      random_segment(PHASE_ITEMS);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: pop on empty, rejected and accepted edges, rising button,
      // both lines at once, two events from one tick
      add_item(reeq_pkg::FUNC_POP, 1'b0, 1'b0, 1'b0);
      gen_btn = 1'b0;
      hold_levels(1);
      gen_btn = 1'b1;
      hold_levels(7);
      gen_a   = 1'b0;
      gen_b   = 1'b0;
      gen_btn = 1'b0;
      hold_levels(7);
      gen_a   = 1'b1;
      gen_btn = 1'b1;
      hold_levels(7);
      gen_a = 1'b0;
      gen_b = 1'b1;
      hold_levels(1);
      add_item(reeq_pkg::FUNC_POP, 1'b1, 1'b1, 1'b1);

      random_segment(PHASE_ITEMS);
      run_phase(0, 0, 84, 0);
      run_phase(255, 255, 0, 84);
      run_phase(3, 10, 37, 37);
      run_phase(1, 2, 0, 0);
      run_phase($urandom_range(0, 12), $urandom_range(0, 30), 84, 0);
      run_phase(255, 0, 0, 84);
      run_phase(0, 255, 37, 37);

      wait_idle();
      repeat (4) @(posedge clock);
      if (mismatches == 0 && expected_rsps.size() == 0) begin
         $display("tb_rotary_encoder_event_queue_core: PASS");
      end else begin
         $display("tb_rotary_encoder_event_queue_core: FAIL");
      end
      $finish;
   end

endmodule
